[rtl/core/stct_pkg.sv]
`timescale 1ns / 1ps

package stct_pkg;

	localparam int PARENT_SLOTS = 16;
	localparam int CHILD_SLOTS  = 64;
	localparam int ID_W         = 32;
	localparam int PEND_W       = 7;
	localparam int PIDX_W       = (PARENT_SLOTS > 1) ? $clog2(PARENT_SLOTS) : 1;
	localparam int CIDX_W       = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
	localparam int SIDX_W       = (PIDX_W > CIDX_W) ? PIDX_W : CIDX_W;
	localparam int AUX_W        = (PEND_W > PIDX_W) ? PEND_W : PIDX_W;
	localparam int PWORD_W      = ID_W + PEND_W;
	localparam int CWORD_W      = ID_W + PIDX_W;

	localparam logic [PEND_W-1:0] PENDING_MAX = PEND_W'(127);

	typedef enum logic [1:0] {
		REQ_START_PARENT = 2'd0,
		REQ_START_CHILD  = 2'd1,
		REQ_FINISH_CHILD = 2'd2,
		REQ_UNUSED       = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_IGNORED = 2'd1,
		STS_UNKNOWN = 2'd2,
		STS_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PSCAN,
		ST_PDRAIN,
		ST_PDECIDE,
		ST_CSCAN,
		ST_CDRAIN,
		ST_CDECIDE,
		ST_PREAD,
		ST_PUPDATE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]      req_type;
		logic [ID_W-1:0] task_id;
	} req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] new_id;
		logic            completed;
		logic [ID_W-1:0] completed_parent;
	} rsp_t;

	typedef struct packed {
		logic              clr;
		logic              step;
		logic              ent_valid;
		logic [SIDX_W-1:0] idx;
	} scan_ctl_t;

	typedef struct packed {
		logic              hit;
		logic [SIDX_W-1:0] hit_idx;
		logic [AUX_W-1:0]  hit_aux;
		logic              free;
		logic [SIDX_W-1:0] free_idx;
	} scan_res_t;

endpackage

[rtl/core/stct_ram.sv]
`timescale 1ns / 1ps

module stct_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/stct_scan.sv]
`timescale 1ns / 1ps

module stct_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stct_pkg::scan_ctl_t               ctl,
	input  logic [stct_pkg::ID_W-1:0]         key,
	input  logic [stct_pkg::AUX_W-1:0]        aux,
	input  logic [stct_pkg::ID_W-1:0]         target,
	output stct_pkg::scan_res_t               res
);

	logic                            hit_q;
	logic                            free_q;
	logic [stct_pkg::SIDX_W-1:0]     hit_idx_q;
	logic [stct_pkg::AUX_W-1:0]      hit_aux_q;
	logic [stct_pkg::SIDX_W-1:0]     free_idx_q;
	logic                            match;
	logic                            take_hit;
	logic                            take_free;

	// shared comparator
	assign match     = ctl.ent_valid && (key == target);
	assign take_hit  = !ctl.clr && ctl.step && match && !hit_q;
	assign take_free = !ctl.clr && ctl.step && !ctl.ent_valid && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q <= ctl.idx;
			hit_aux_q <= aux;
		end
		if (take_free) begin
			free_idx_q <= ctl.idx;
		end
	end

	assign res = '{hit: hit_q, hit_idx: hit_idx_q, hit_aux: hit_aux_q,
		free: free_q, free_idx: free_idx_q};

	a_clr_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |=> !res.hit && !res.free)
		else $error("scan result not cleared");

	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit && !ctl.clr |=> res.hit)
		else $error("hit dropped without clear");

	a_free_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.free) |-> $past(ctl.step && !ctl.ent_valid))
		else $error("free slot taken from a live entry");

	a_hit_not_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.hit && res.free |-> res.hit_idx != res.free_idx)
		else $error("same slot both live and free");

endmodule

[rtl/core/split_task_completion_tracker_core.sv]
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  stct_pkg::req_t
// rsp       out        rsp_valid / rsp_ready  stct_pkg::rsp_t
// cfg       in         cfg_we                 cfg_wdata (invalid id)
//
// one request at a time; a single comparator walks the tables, one entry a cycle
// start parent: parent table scan, then response
// start child: parent table scan, then child table scan unless rejected early
// finish child: child scan, parent update on hit; ignored requests skip scans
// reset clears valid bits, id counters and invalid id; no clearing pass
// req_ready is low from accept until the response is taken

module split_task_completion_tracker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  stct_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output stct_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [stct_pkg::ID_W-1:0]     cfg_wdata
);

	stct_pkg::state_t                    state_q;
	stct_pkg::state_t                    state_nxt;
	stct_pkg::req_t                      req_q;
	stct_pkg::rsp_t                      rsp_q;
	stct_pkg::rsp_t                      rsp_nxt;
	logic                                rsp_load;
	logic [stct_pkg::ID_W-1:0]           inv_q;
	logic [stct_pkg::ID_W-1:0]           next_pid_q;
	logic [stct_pkg::ID_W-1:0]           next_cid_q;
	logic [stct_pkg::ID_W-1:0]           cand_p;
	logic [stct_pkg::ID_W-1:0]           cand_c;
	logic                                pid_adv;
	logic                                cid_adv;
	logic [stct_pkg::PARENT_SLOTS-1:0]   pvalid_q;
	logic [stct_pkg::CHILD_SLOTS-1:0]    cvalid_q;
	logic                                pv_wr;
	logic [stct_pkg::PIDX_W-1:0]         pv_idx;
	logic                                pv_val;
	logic                                cv_wr;
	logic [stct_pkg::CIDX_W-1:0]         cv_idx;
	logic                                cv_val;
	logic [stct_pkg::SIDX_W-1:0]         cnt_q;
	logic                                step_s1;
	logic                                ctbl_s1;
	logic [stct_pkg::SIDX_W-1:0]         idx_s1;
	logic [stct_pkg::PIDX_W-1:0]         par_idx_q;
	logic [stct_pkg::PEND_W-1:0]         par_pend_q;
	logic                                scan_clr;

	logic                                p_we;
	logic [stct_pkg::PIDX_W-1:0]         p_waddr;
	logic [stct_pkg::PWORD_W-1:0]        p_wdata;
	logic                                p_re;
	logic [stct_pkg::PIDX_W-1:0]         p_raddr;
	logic [stct_pkg::PWORD_W-1:0]        p_rdata;
	logic                                c_we;
	logic [stct_pkg::CIDX_W-1:0]         c_waddr;
	logic [stct_pkg::CWORD_W-1:0]        c_wdata;
	logic                                c_re;
	logic [stct_pkg::CIDX_W-1:0]         c_raddr;
	logic [stct_pkg::CWORD_W-1:0]        c_rdata;

	logic [stct_pkg::ID_W-1:0]           p_rkey;
	logic [stct_pkg::PEND_W-1:0]         p_rpend;
	logic [stct_pkg::ID_W-1:0]           c_rkey;
	logic [stct_pkg::PIDX_W-1:0]         c_rowner;
	logic [stct_pkg::PIDX_W-1:0]         owner;

	stct_pkg::scan_ctl_t                 scan_ctl;
	stct_pkg::scan_res_t                 scan_res;
	logic [stct_pkg::ID_W-1:0]           scan_key;
	logic [stct_pkg::AUX_W-1:0]          scan_aux;
	logic [stct_pkg::ID_W-1:0]           scan_target;

	assign p_rkey   = p_rdata[stct_pkg::PEND_W +: stct_pkg::ID_W];
	assign p_rpend  = p_rdata[stct_pkg::PEND_W-1:0];
	assign c_rkey   = c_rdata[stct_pkg::PIDX_W +: stct_pkg::ID_W];
	assign c_rowner = c_rdata[stct_pkg::PIDX_W-1:0];
	assign owner    = scan_res.hit_aux[stct_pkg::PIDX_W-1:0];

	// next id, skipping the invalid id
	assign cand_p = (next_pid_q == inv_q) ? next_pid_q + 1'b1 : next_pid_q;
	assign cand_c = (next_cid_q == inv_q) ? next_cid_q + 1'b1 : next_cid_q;

	stct_ram #(
		.DEPTH(stct_pkg::PARENT_SLOTS),
		.WIDTH(stct_pkg::PWORD_W)
	) u_parent_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.re   (p_re),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	stct_ram #(
		.DEPTH(stct_pkg::CHILD_SLOTS),
		.WIDTH(stct_pkg::CWORD_W)
	) u_child_ram (
		.clk  (clk),
		.we   (c_we),
		.waddr(c_waddr),
		.wdata(c_wdata),
		.re   (c_re),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	// scan feed, one entry per cycle behind the ram read
	always_comb begin
		if (ctbl_s1) begin
			scan_key         = c_rkey;
			scan_aux         = stct_pkg::AUX_W'(c_rowner);
			scan_ctl.ent_valid = cvalid_q[idx_s1[stct_pkg::CIDX_W-1:0]];
			scan_target      = (req_q.req_type == stct_pkg::REQ_START_CHILD) ?
				cand_c : req_q.task_id;
		end else begin
			scan_key         = p_rkey;
			scan_aux         = stct_pkg::AUX_W'(p_rpend);
			scan_ctl.ent_valid = pvalid_q[idx_s1[stct_pkg::PIDX_W-1:0]];
			scan_target      = (req_q.req_type == stct_pkg::REQ_START_PARENT) ?
				cand_p : req_q.task_id;
		end
		scan_ctl.clr  = scan_clr;
		scan_ctl.step = step_s1;
		scan_ctl.idx  = idx_s1;
	end

	stct_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (scan_ctl),
		.key   (scan_key),
		.aux   (scan_aux),
		.target(scan_target),
		.res   (scan_res)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			stct_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (req.req_type)
						stct_pkg::REQ_START_PARENT: state_nxt = stct_pkg::ST_PSCAN;
						stct_pkg::REQ_START_CHILD: begin
							state_nxt = (req.task_id == inv_q) ?
								stct_pkg::ST_RESP : stct_pkg::ST_PSCAN;
						end
						stct_pkg::REQ_FINISH_CHILD: begin
							state_nxt = (req.task_id == inv_q) ?
								stct_pkg::ST_RESP : stct_pkg::ST_CSCAN;
						end
						default: state_nxt = stct_pkg::ST_RESP;
					endcase
				end
			end
			stct_pkg::ST_PSCAN: begin
				if (cnt_q == stct_pkg::SIDX_W'(stct_pkg::PARENT_SLOTS - 1)) begin
					state_nxt = stct_pkg::ST_PDRAIN;
				end
			end
			stct_pkg::ST_PDRAIN: state_nxt = stct_pkg::ST_PDECIDE;
			stct_pkg::ST_PDECIDE: begin
				if (req_q.req_type == stct_pkg::REQ_START_CHILD && scan_res.hit &&
					scan_res.hit_aux[stct_pkg::PEND_W-1:0] < stct_pkg::PENDING_MAX) begin
					state_nxt = stct_pkg::ST_CSCAN;
				end else begin
					state_nxt = stct_pkg::ST_RESP;
				end
			end
			stct_pkg::ST_CSCAN: begin
				if (cnt_q == stct_pkg::SIDX_W'(stct_pkg::CHILD_SLOTS - 1)) begin
					state_nxt = stct_pkg::ST_CDRAIN;
				end
			end
			stct_pkg::ST_CDRAIN: state_nxt = stct_pkg::ST_CDECIDE;
			stct_pkg::ST_CDECIDE: begin
				if (req_q.req_type == stct_pkg::REQ_FINISH_CHILD && scan_res.hit) begin
					state_nxt = stct_pkg::ST_PREAD;
				end else begin
					state_nxt = stct_pkg::ST_RESP;
				end
			end
			stct_pkg::ST_PREAD: state_nxt = stct_pkg::ST_PUPDATE;
			stct_pkg::ST_PUPDATE: state_nxt = stct_pkg::ST_RESP;
			stct_pkg::ST_RESP: begin
				if (rsp_ready) begin
					state_nxt = stct_pkg::ST_IDLE;
				end
			end
			default: state_nxt = stct_pkg::ST_IDLE;
		endcase
	end

	// outputs and table updates
	always_comb begin
		req_ready = (state_q == stct_pkg::ST_IDLE);
		rsp_valid = (state_q == stct_pkg::ST_RESP);
		scan_clr  = 1'b0;
		rsp_load  = 1'b0;
		rsp_nxt   = '{status: stct_pkg::STS_OK, new_id: inv_q, completed: 1'b0,
			completed_parent: '0};
		pid_adv   = 1'b0;
		cid_adv   = 1'b0;
		pv_wr     = 1'b0;
		pv_idx    = scan_res.free_idx[stct_pkg::PIDX_W-1:0];
		pv_val    = 1'b1;
		cv_wr     = 1'b0;
		cv_idx    = scan_res.free_idx[stct_pkg::CIDX_W-1:0];
		cv_val    = 1'b1;
		p_we      = 1'b0;
		p_waddr   = scan_res.free_idx[stct_pkg::PIDX_W-1:0];
		p_wdata   = {cand_p, stct_pkg::PEND_W'(0)};
		p_re      = 1'b0;
		p_raddr   = cnt_q[stct_pkg::PIDX_W-1:0];
		c_we      = 1'b0;
		c_waddr   = scan_res.free_idx[stct_pkg::CIDX_W-1:0];
		c_wdata   = {cand_c, par_idx_q};
		c_re      = 1'b0;
		c_raddr   = cnt_q[stct_pkg::CIDX_W-1:0];
		unique case (state_q)
			stct_pkg::ST_IDLE: begin
				if (req_valid) begin
					scan_clr = 1'b1;
					if (req.req_type == stct_pkg::REQ_UNUSED ||
						(req.req_type != stct_pkg::REQ_START_PARENT &&
						req.task_id == inv_q)) begin
						rsp_load       = 1'b1;
						rsp_nxt.status = stct_pkg::STS_IGNORED;
					end
				end
			end
			stct_pkg::ST_PSCAN: p_re = 1'b1;
			stct_pkg::ST_PDECIDE: begin
				if (req_q.req_type == stct_pkg::REQ_START_PARENT) begin
					rsp_load = 1'b1;
					if (!scan_res.free) begin
						rsp_nxt.status = stct_pkg::STS_FULL;
					end else begin
						pid_adv = 1'b1;
						if (scan_res.hit) begin
							rsp_nxt.status = stct_pkg::STS_FULL;
						end else begin
							p_we           = 1'b1;
							pv_wr          = 1'b1;
							rsp_nxt.new_id = cand_p;
						end
					end
				end else if (!scan_res.hit) begin
					rsp_load       = 1'b1;
					rsp_nxt.status = stct_pkg::STS_UNKNOWN;
				end else if (scan_res.hit_aux[stct_pkg::PEND_W-1:0] >=
					stct_pkg::PENDING_MAX) begin
					rsp_load       = 1'b1;
					rsp_nxt.status = stct_pkg::STS_FULL;
				end else begin
					scan_clr = 1'b1;
				end
			end
			stct_pkg::ST_CSCAN: c_re = 1'b1;
			stct_pkg::ST_CDECIDE: begin
				if (req_q.req_type == stct_pkg::REQ_START_CHILD) begin
					rsp_load = 1'b1;
					if (!scan_res.free) begin
						rsp_nxt.status = stct_pkg::STS_FULL;
					end else begin
						cid_adv = 1'b1;
						if (scan_res.hit) begin
							rsp_nxt.status = stct_pkg::STS_FULL;
						end else begin
							c_we           = 1'b1;
							cv_wr          = 1'b1;
							p_we           = 1'b1;
							p_waddr        = par_idx_q;
							p_wdata        = {req_q.task_id, par_pend_q + 1'b1};
							rsp_nxt.new_id = cand_c;
						end
					end
				end else if (!scan_res.hit) begin
					rsp_load       = 1'b1;
					rsp_nxt.status = stct_pkg::STS_UNKNOWN;
				end else begin
					cv_wr  = 1'b1;
					cv_idx = scan_res.hit_idx[stct_pkg::CIDX_W-1:0];
					cv_val = 1'b0;
				end
			end
			stct_pkg::ST_PREAD: begin
				p_re    = 1'b1;
				p_raddr = owner;
			end
			stct_pkg::ST_PUPDATE: begin
				rsp_load = 1'b1;
				if (pvalid_q[owner] && p_rpend != '0) begin
					p_we    = 1'b1;
					p_waddr = owner;
					p_wdata = {p_rkey, p_rpend - 1'b1};
					if (p_rpend == stct_pkg::PEND_W'(1)) begin
						pv_wr                    = 1'b1;
						pv_idx                   = owner;
						pv_val                   = 1'b0;
						rsp_nxt.completed        = 1'b1;
						rsp_nxt.completed_parent = p_rkey;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= stct_pkg::ST_IDLE;
			inv_q      <= '0;
			next_pid_q <= '0;
			next_cid_q <= '0;
			pvalid_q   <= '0;
			cvalid_q   <= '0;
			cnt_q      <= '0;
			step_s1    <= 1'b0;
			ctbl_s1    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				inv_q <= cfg_wdata;
			end
			if (pid_adv) begin
				next_pid_q <= cand_p + 1'b1;
			end
			if (cid_adv) begin
				next_cid_q <= cand_c + 1'b1;
			end
			if (pv_wr) begin
				pvalid_q[pv_idx] <= pv_val;
			end
			if (cv_wr) begin
				cvalid_q[cv_idx] <= cv_val;
			end
			if (state_q == stct_pkg::ST_PSCAN || state_q == stct_pkg::ST_CSCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			step_s1 <= (state_q == stct_pkg::ST_PSCAN || state_q == stct_pkg::ST_CSCAN);
			ctbl_s1 <= (state_q == stct_pkg::ST_CSCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
		if (state_q == stct_pkg::ST_PDECIDE) begin
			par_idx_q  <= scan_res.hit_idx[stct_pkg::PIDX_W-1:0];
			par_pend_q <= scan_res.hit_aux[stct_pkg::PEND_W-1:0];
		end
	end

	assign rsp = rsp_q;

endmodule
